@@ design/pip_pkg.sv @@
package pip_pkg;

    // Default coordinate width of the query point and the vertices.
    localparam int unsigned COORD_WIDTH_DEF = 16;

    // Per-item flags that travel with a vertex down the pipeline.
    typedef struct packed {
        logic first;    // vertex opens a polygon
        logic last;     // vertex closes a polygon
    } t_flags;

    // Load enables of the difference and product stages of the edge pipeline.
    typedef struct packed {
        logic ld_diff;  // load the difference stage
        logic ld_prod;  // load the product stage
    } t_stage_ld;

endpackage

@@ design/point_in_polygon_crossing.sv @@
// Crossing-number point-in-polygon test over a stream of vertices.
//
// Slave side: one word per polygon vertex. tdata carries point_x, point_y,
// vertex_x and vertex_y; the point is sampled only on the first vertex of a
// polygon. tlast marks the final vertex, which also closes the polygon back
// to its first vertex. Master side: one word per polygon, tdata[0] = inside.
//
// Throughput: one vertex per cycle while no stall backs up from the receiver.
// Each vertex runs through a capture register, a difference stage, a product
// stage (multipliers for the previous and closing edges) and a compare/parity stage that
// writes the output register that drives o_m_axis_tvalid and o_m_axis_tdata.
// A one-vertex polygon reports outside.
//
// Reset (synchronous, active low) empties the pipeline and the output register
// and arms the block for the first vertex of a new polygon.
// When the receiver stalls, the output word holds and the stages behind it
// keep filling; only a closing vertex waits on a full output register, and the
// stall then backs up stage by stage to o_s_axis_tready.
module point_in_polygon_crossing #(
    parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // point_x, point_y, vertex_x, vertex_y (lowest bits first), zero padded
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // inside_res in bit 0, zero padded
    output logic [7:0]                             o_m_axis_tdata
);
    import pip_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;

    logic                 accept;
    logic                 rdy1, rdy2, rdy3, out_free, adv3;
    logic                 r_v1, r_v2, r_v3;
    logic                 r_last2, r_last3;
    t_flags               flags1;
    t_stage_ld            ld;
    logic signed [CW-1:0] vx, vy, px, py, qx, qy, fx, fy;
    logic                 tog_a, tog_b, inside_bit;

    // Hold a stage while its successor is full and stalled; a stage is free
    // when empty. Only a closing vertex needs room in the output register.
    assign rdy3 = !r_v3 || !r_last3 || out_free;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign adv3 = r_v3 && rdy3;

    assign o_s_axis_tready = rdy1;
    assign accept          = i_s_axis_tvalid && rdy1;

    assign ld.ld_diff = rdy2;
    assign ld.ld_prod = rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_last2 <= 1'b0;
            r_last3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2    <= r_v1;
                r_last2 <= flags1.last;
            end
            if (rdy3) begin
                r_v3    <= r_v2;
                r_last3 <= r_last2;
            end
        end
    end

    pip_capture #(
        .COORD_WIDTH(CW)
    ) u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_point_x     (i_s_axis_tdata[CW-1:0]),
        .i_point_y     (i_s_axis_tdata[2*CW-1:CW]),
        .i_vertex_x    (i_s_axis_tdata[3*CW-1:2*CW]),
        .i_vertex_y    (i_s_axis_tdata[4*CW-1:3*CW]),
        .i_last_vertex (i_s_axis_tlast),
        .o_flags       (flags1),
        .o_vx          (vx),
        .o_vy          (vy),
        .o_px          (px),
        .o_py          (py),
        .o_qx          (qx),
        .o_qy          (qy),
        .o_fx          (fx),
        .o_fy          (fy)
    );

    // Edge from the previous vertex to this one; none on the opening vertex.
    pip_edge #(
        .COORD_WIDTH(CW)
    ) u_edge_prev (
        .i_clk    (i_clk),
        .i_ld     (ld),
        .i_active (r_v1 && !flags1.first),
        .i_ax     (px),
        .i_ay     (py),
        .i_bx     (vx),
        .i_by     (vy),
        .i_qx     (qx),
        .i_qy     (qy),
        .o_toggle (tog_a)
    );

    // Closing edge from the final vertex back to the first one.
    pip_edge #(
        .COORD_WIDTH(CW)
    ) u_edge_close (
        .i_clk    (i_clk),
        .i_ld     (ld),
        .i_active (r_v1 && flags1.last && !flags1.first),
        .i_ax     (vx),
        .i_ay     (vy),
        .i_bx     (fx),
        .i_by     (fy),
        .i_qx     (qx),
        .i_qy     (qy),
        .o_toggle (tog_b)
    );

    pip_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (adv3),
        .i_last     (r_last3),
        .i_toggle_a (tog_a),
        .i_toggle_b (tog_b),
        .i_m_ready  (i_m_axis_tready),
        .o_out_free (out_free),
        .o_valid    (o_m_axis_tvalid),
        .o_inside   (inside_bit)
    );

    assign o_m_axis_tdata = {7'b0, inside_bit};

endmodule

@@ design/pip_capture.sv @@
module pip_capture #(
    parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic                          i_last_vertex,
    output pip_pkg::t_flags               o_flags,
    output logic signed [COORD_WIDTH-1:0] o_vx,
    output logic signed [COORD_WIDTH-1:0] o_vy,
    output logic signed [COORD_WIDTH-1:0] o_px,
    output logic signed [COORD_WIDTH-1:0] o_py,
    output logic signed [COORD_WIDTH-1:0] o_qx,
    output logic signed [COORD_WIDTH-1:0] o_qy,
    output logic signed [COORD_WIDTH-1:0] o_fx,
    output logic signed [COORD_WIDTH-1:0] o_fy
);
    import pip_pkg::*;

    logic                          r_in_poly;
    t_flags                        r_flags;
    logic signed [COORD_WIDTH-1:0] r_vx, r_vy, r_px, r_py;
    logic signed [COORD_WIDTH-1:0] r_qx, r_qy, r_fx, r_fy;

    // r_vx/r_vy hold the newest vertex; the one before it shifts into r_px/r_py.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_poly <= 1'b0;
            r_flags   <= '0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_px      <= '0;
            r_py      <= '0;
            r_qx      <= '0;
            r_qy      <= '0;
            r_fx      <= '0;
            r_fy      <= '0;
        end else if (i_accept) begin
            r_flags.first <= !r_in_poly;
            r_flags.last  <= i_last_vertex;
            r_in_poly     <= !i_last_vertex;
            r_px          <= r_vx;
            r_py          <= r_vy;
            r_vx          <= i_vertex_x;
            r_vy          <= i_vertex_y;
            if (!r_in_poly) begin
                r_qx <= i_point_x;
                r_qy <= i_point_y;
                r_fx <= i_vertex_x;
                r_fy <= i_vertex_y;
            end
        end
    end

    assign o_flags = r_flags;
    assign o_vx    = r_vx;
    assign o_vy    = r_vy;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_fx    = r_fx;
    assign o_fy    = r_fy;

endmodule

@@ design/pip_edge.sv @@
module pip_edge #(
    parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  pip_pkg::t_stage_ld            i_ld,
    input  logic                          i_active,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_qx,
    input  logic signed [COORD_WIDTH-1:0] i_qy,
    output logic                          o_toggle
);
    import pip_pkg::*;

    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned PW = 2 * DW;

    logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, qx_e, qy_e;
    logic                 straddle;

    logic                 r_str_d;
    logic signed [DW-1:0] r_d, r_lx, r_rx, r_ry;

    logic                 r_str_p;
    logic                 r_dpos;
    logic signed [PW-1:0] r_lhs, r_rhs;

    assign ax_e = DW'(i_ax);
    assign ay_e = DW'(i_ay);
    assign bx_e = DW'(i_bx);
    assign by_e = DW'(i_by);
    assign qx_e = DW'(i_qx);
    assign qy_e = DW'(i_qy);

    // Edge crosses the horizontal line through the query point.
    assign straddle = (i_by > i_qy) != (i_ay > i_qy);

    always_ff @(posedge i_clk) begin
        if (i_ld.ld_diff) begin
            r_str_d <= i_active && straddle;
            r_d     <= ay_e - by_e;
            r_lx    <= qx_e - bx_e;
            r_rx    <= ax_e - bx_e;
            r_ry    <= qy_e - by_e;
        end
        if (i_ld.ld_prod) begin
            r_str_p <= r_str_d;
            r_dpos  <= !r_d[DW-1];
            r_lhs   <= PW'(r_lx) * PW'(r_d);
            r_rhs   <= PW'(r_rx) * PW'(r_ry);
        end
    end

    // Query strictly left of the crossing; flip the compare when d is negative.
    assign o_toggle = r_str_p && (r_dpos ? (r_lhs < r_rhs) : (r_rhs < r_lhs));

endmodule

@@ design/pip_accum.sv @@
module pip_accum (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_advance,
    input  logic i_last,
    input  logic i_toggle_a,
    input  logic i_toggle_b,
    input  logic i_m_ready,
    output logic o_out_free,
    output logic o_valid,
    output logic o_inside
);
    import pip_pkg::*;

    logic r_parity;
    logic r_valid;
    logic r_inside;
    logic n_parity;

    assign n_parity = r_parity ^ i_toggle_a ^ i_toggle_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
            r_valid  <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            if (i_advance && i_last) begin
                r_inside <= n_parity;
                r_parity <= 1'b0;
                r_valid  <= 1'b1;
            end else begin
                if (i_advance) begin
                    r_parity <= n_parity;
                end
                if (i_m_ready) begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_free = !r_valid || i_m_ready;
    assign o_valid    = r_valid;
    assign o_inside   = r_inside;

endmodule

@@ tb/sv/point_in_polygon_crossing_test.sv @@
`timescale 1ns / 1ps

module point_in_polygon_crossing_test;

    localparam int CW         = pip_pkg::COORD_WIDTH_DEF;
    localparam int TDW        = ((4*CW+7)/8)*8;
    localparam int IDLE_PCT   = 17;
    localparam int ITEM_GOAL  = 1000;
    localparam int STALL_MAX  = 5000;   // cycles with no word moving on either side
    localparam int DRAIN_WAIT = 16;     // extra wait once no output word is pending

    localparam int COORD_MAX = (1 << (CW-1)) - 1;
    localparam int COORD_MIN = -(1 << (CW-1));

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_vertex;

    // Crossing-number predictor: tracks the open polygon and queues one inside
    // flag per closing vertex.
    class inside_scoreboard;
        t_vertex first_v;
        t_vertex prev_v;
        t_vertex query;
        bit      parity;
        bit      open_poly;
        bit      inside_q[$];
        int      errors;

        function new();
            first_v   = '{x: '0, y: '0};
            prev_v    = '{x: '0, y: '0};
            query     = '{x: '0, y: '0};
            parity    = 1'b0;
            open_poly = 1'b0;
            errors    = 0;
        endfunction

        // Edge a->b toggles when it straddles the query height and the query
        // point lies strictly left of the crossing; compare cross-multiplied.
        function bit edge_flips(t_vertex a, t_vertex b);
            longint xa, ya, xb, yb, qx, qy, d, lhs, rhs;
            xa = a.x; ya = a.y; xb = b.x; yb = b.y;
            qx = query.x; qy = query.y;
            if ((yb > qy) == (ya > qy))
                return 1'b0;
            d   = ya - yb;
            lhs = (qx - xb) * d;
            rhs = (xa - xb) * (qy - yb);
            return (d > 0) ? (lhs < rhs) : (rhs < lhs);
        endfunction

        function void note_vertex(t_vertex pt, t_vertex v, bit last);
            if (!open_poly) begin
                query     = pt;
                first_v   = v;
                parity    = 1'b0;
                open_poly = 1'b1;
            end else begin
                if (edge_flips(prev_v, v))
                    parity = ~parity;
                if (last && edge_flips(v, first_v))
                    parity = ~parity;
            end
            prev_v = v;
            if (last) begin
                inside_q.push_back(parity);
                parity    = 1'b0;
                open_poly = 1'b0;
            end
        endfunction

        function void check_inside(bit got);
            bit want;
            if (inside_q.size() == 0) begin
                $display("%0t: unexpected inside word, expected none, got %0b", $time, got);
                errors++;
            end else begin
                want = inside_q.pop_front();
                if (got !== want) begin
                    $display("%0t: inside mismatch, expected %0b, got %0b", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return inside_q.size();
        endfunction
    endclass

    // Clock, reset and block ports; every input starts at a known value.
    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_axis_tvalid = 1'b0;
    logic           o_s_axis_tready;
    logic [TDW-1:0] i_s_axis_tdata = '0;    // point_x, point_y, vertex_x, vertex_y
    logic           i_s_axis_tlast = 1'b0;
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready = 1'b0;
    logic [7:0]     o_m_axis_tdata;         // inside_res, zero padded

    inside_scoreboard sb = new();
    bit               no_idle = 1'b0;       // set during the stretch without gaps
    int               sent_words = 0;
    int               stall_cnt = 0;

    point_in_polygon_crossing i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [CW-1:0] clamp_coord(int v);
        if (v > COORD_MAX)
            return CW'(COORD_MAX);
        if (v < COORD_MIN)
            return CW'(COORD_MIN);
        return CW'(v);
    endfunction

    function automatic t_vertex mk(int x, int y);
        return '{x: clamp_coord(x), y: clamp_coord(y)};
    endfunction

    function automatic t_vertex any_vertex();
        return '{x: CW'($urandom()), y: CW'($urandom())};
    endfunction

    // Offer one vertex word, with random gaps ahead of it, and hold it until
    // the block takes it. tvalid stays high across back-to-back words.
    task automatic send_vertex(t_vertex pt, t_vertex v, bit last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= TDW'({v.y, v.x, pt.y, pt.x});
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_vertex(pt, v, last);
        sent_words++;
    endtask

    // Send a whole polygon. The point rides on the first vertex; later words
    // carry junk in the point fields, which the block must ignore.
    task automatic send_polygon(t_vertex pt, t_vertex verts[$]);
        foreach (verts[i])
            send_vertex((i == 0) ? pt : any_vertex(), verts[i], i == verts.size() - 1);
    endtask

    function automatic int pick_extreme(int qv);
        int vals[8];
        vals = '{COORD_MIN, COORD_MIN + 1, -1, 0, 1, COORD_MAX - 1, COORD_MAX, qv};
        return vals[$urandom_range(7)];
    endfunction

    // Random polygon: mostly a cluster around the point (small radius makes
    // ties on vertex height and on the crossing common), some full-range noise
    // and some built from extreme values.
    task automatic send_random_polygon();
        t_vertex pt;
        t_vertex verts[$];
        int      n, mode, cx, cy, r;
        int      sel;
        sel = $urandom_range(99);
        if (sel < 5)
            n = 1;
        else if (sel < 10)
            n = 2;
        else if (sel < 13)
            n = $urandom_range(11, 40);
        else
            n = $urandom_range(3, 10);
        mode = $urandom_range(99);
        cx   = int'($urandom_range(65535)) - 32768;
        cy   = int'($urandom_range(65535)) - 32768;
        r    = 1 << $urandom_range(1, 15);
        if (mode < 65)
            pt = mk(cx + int'($urandom_range(2*r)) - r, cy + int'($urandom_range(2*r)) - r);
        else if (mode < 85)
            pt = any_vertex();
        else
            pt = mk(pick_extreme(0), pick_extreme(0));
        repeat (n) begin
            if (mode < 65)
                verts.push_back(mk(cx + int'($urandom_range(2*r)) - r,
                                   cy + int'($urandom_range(2*r)) - r));
            else if (mode < 85)
                verts.push_back(any_vertex());
            else
                verts.push_back(mk(pick_extreme(pt.x), pick_extreme(pt.y)));
        end
        send_polygon(pt, verts);
    endtask

    // Output side: check each accepted word, then pick the next ready.
    // The watchdog counts cycles where no word moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_inside(o_m_axis_tdata[0]);
            i_m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_vertex verts[$];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-vertex polygon: always outside.
        send_polygon(mk(0, 0), '{mk(COORD_MAX, COORD_MIN)});
        // Two-vertex polygon: the single edge is tested twice.
        send_polygon(mk(0, 0), '{mk(-10, -10), mk(10, 10)});
        // Full-range square with horizontal edges, point in the middle.
        verts = '{mk(COORD_MIN, COORD_MIN), mk(COORD_MAX, COORD_MIN),
                  mk(COORD_MAX, COORD_MAX), mk(COORD_MIN, COORD_MAX)};
        send_polygon(mk(0, 0), verts);
        // Same square, point on the right edge: not strictly left.
        send_polygon(mk(COORD_MAX, 0), verts);
        // Point exactly on a slanted edge's crossing.
        send_polygon(mk(5, 0), '{mk(0, -10), mk(10, 10), mk(0, 10)});
        // Point at extreme coordinates outside a wide triangle.
        send_polygon(mk(COORD_MIN, COORD_MAX),
                     '{mk(COORD_MAX, COORD_MAX), mk(0, COORD_MIN), mk(COORD_MIN, COORD_MIN)});
        // Diamond with vertices at the point's height.
        send_polygon(mk(0, 0), '{mk(0, -5), mk(5, 0), mk(0, 5), mk(-5, 0)});

        // Random polygons, with one long stretch where neither side idles.
        while (sent_words < ITEM_GOAL) begin
            no_idle = (sent_words >= 400) && (sent_words < 650);
            send_random_polygon();
        end
        no_idle = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected word, then wait out DRAIN_WAIT.
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
